// ===== design/skt_pkg.sv =====
// Shared types and constants for the sorted key table.
// Holds operation and status codes and the controller command and state types.
// No dependencies.
package skt_pkg;

  localparam int KeyWords = 8;
  localparam int KeyBits = 64 * KeyWords;
  localparam int DefaultCapacity = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

// ===== design/skt_ctrl.sv =====
// Controller state machine for the sorted key table.
// Sequences capture, execution and response; uses skt_pkg.
module skt_ctrl import skt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) cmd.capture |=> cmd.execute)
    else $error("execute must follow capture");
  assert property (@(posedge clk) disable iff (rst) cmd.execute |=> out_valid)
    else $error("response must follow execute");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input taken while a response waits");

endmodule

// ===== design/skt_datapath.sv =====
// Datapath for the sorted key table: a row of key cells with per-cell compare.
// Performs insert, remove and lookup on the execute command; uses skt_pkg.
module skt_datapath import skt_pkg::*; #(
  parameter int CAPACITY = DefaultCapacity
) (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  input  logic [1:0]    operation,
  input  logic [2:0]    entry_index,
  input  logic [KeyBits-1:0] key_in,
  output logic [1:0]    status,
  output logic          found,
  output logic [3:0]    entry_count
);

  localparam int CountBits = $clog2(CAPACITY + 1);

  logic [KeyBits-1:0]   keys [CAPACITY];
  logic [KeyBits-1:0]   key;
  logic [1:0]           op;
  logic [2:0]           idx;
  logic [CountBits-1:0] count;
  logic [KeyBits-1:0]   canon;
  logic [63:0]          ended;
  logic [CAPACITY-1:0]  gt;
  logic [CAPACITY-1:0]  eq;
  logic                 full;
  logic                 bad_idx;

  always_comb begin
    ended[0] = 1'b0;
    for (int b = 1; b < 64; b++) begin
      ended[b] = ended[b-1] | (key_in[KeyBits-8*b +: 8] == 8'd0);
    end
    for (int b = 0; b < 64; b++) begin
      canon[KeyBits-8-8*b +: 8] = ended[b] ? 8'd0 : key_in[KeyBits-8-8*b +: 8];
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (CountBits'(i) < count) && (key < keys[i]);
      eq[i] = (CountBits'(i) < count) && (key == keys[i]);
    end
  end

  assign full = (count == CountBits'(CAPACITY));
  assign bad_idx = ({{(CountBits > 3 ? CountBits - 3 : 0){1'b0}}, idx} >= count);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key <= canon;
      op <= operation;
      idx <= entry_index;
    end
    if (cmd.execute) begin
      status <= STATUS_DONE;
      found <= 1'b0;
      case (op_t'(op))
        OP_INSERT: begin
          if (full) begin
            status <= STATUS_FULL;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (i > 0 && gt[(i > 0) ? i-1 : 0]) begin
                keys[i] <= keys[(i > 0) ? i-1 : 0];
              end else if (gt[i] || CountBits'(i) == count) begin
                keys[i] <= key;
              end
            end
          end
        end
        OP_REMOVE: begin
          if (bad_idx) begin
            status <= STATUS_RANGE;
          end else begin
            for (int i = 0; i + 1 < CAPACITY; i++) begin
              if (i >= int'(idx)) begin
                keys[i] <= keys[i+1];
              end
            end
          end
        end
        OP_LOOKUP: found <= |eq;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      if (op_t'(op) == OP_INSERT && !full) begin
        count <= count + 1'b1;
      end else if (op_t'(op) == OP_REMOVE && !bad_idx) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      entry_count <= 4'(count + ((op_t'(op) == OP_INSERT && !full) ? CountBits'(1) : '0)
                     - ((op_t'(op) == OP_REMOVE && !bad_idx) ? CountBits'(1) : '0));
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CountBits'(CAPACITY))
    else $error("entry count beyond capacity");
  assert property (@(posedge clk) disable iff (rst)
    cmd.execute && op_t'(op) == OP_INSERT && full |=> $stable(count))
    else $error("full insert changed the count");
  assert property (@(posedge clk) disable iff (rst)
    cmd.execute && op_t'(op) == OP_REMOVE && bad_idx |=> status == STATUS_RANGE)
    else $error("out of range remove not flagged");

endmodule

// ===== design/sorted_key_table.sv =====
// Top level of the sorted key table.
// Joins skt_ctrl and skt_datapath; uses skt_pkg.
//
// The table keeps up to CAPACITY keys of 64 bytes in ascending byte order.
// Input channel: in_valid and in_stall carry one command transaction with
// operation, entry_index and eight key words. Output channel: out_valid and
// out_stall carry one result transaction with status, found and entry_count.
// Each command gives exactly one result. A command is captured in the cycle it
// is accepted, executed across the row of key cells in the next cycle, and its
// result is then presented in the response state until the receiver takes it.
// One command is in flight at a time: the input is stalled from acceptance
// until its result is taken. While the receiver stalls, the result holds
// steady and no new command is accepted. Reset empties the table; stored key
// contents are not cleared, as entries at or past the count never take part
// in a compare.
module sorted_key_table import skt_pkg::*; #(
  parameter int CAPACITY = DefaultCapacity
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [2:0]  entry_index,
  input  logic [63:0] key_word_0,
  input  logic [63:0] key_word_1,
  input  logic [63:0] key_word_2,
  input  logic [63:0] key_word_3,
  input  logic [63:0] key_word_4,
  input  logic [63:0] key_word_5,
  input  logic [63:0] key_word_6,
  input  logic [63:0] key_word_7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        found,
  output logic [3:0]  entry_count
);

  cmd_t cmd;

  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  skt_datapath #(.CAPACITY(CAPACITY)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .operation   (operation),
    .entry_index (entry_index),
    .key_in      ({key_word_0, key_word_1, key_word_2, key_word_3,
                   key_word_4, key_word_5, key_word_6, key_word_7}),
    .status      (status),
    .found       (found),
    .entry_count (entry_count)
  );

endmodule

// ===== test/sorted_key_table_tb.sv =====
// Testbench for the sorted key table: directed table of commands, then random
// insert, remove, lookup and unused-op traffic checked against a behavioural predictor.
// Depends on skt_pkg and sorted_key_table.
module sorted_key_table_tb import skt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cap = 8;

  typedef logic [63:0] key_t [8];

  typedef struct {
    op_t        op;
    logic [2:0] idx;
    key_t       key;
  } command_t;

  typedef struct packed {
    status_t    st;
    logic       fnd;
    logic [3:0] cnt;
  } answer_t;

  typedef struct {
    command_t cmd;
    logic     has_answer;
    answer_t  ans;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] operation = '0;
  logic [2:0] entry_index = '0;
  logic [63:0] key_word_0 = '0, key_word_1 = '0, key_word_2 = '0, key_word_3 = '0;
  logic [63:0] key_word_4 = '0, key_word_5 = '0, key_word_6 = '0, key_word_7 = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] status;
  logic found;
  logic [3:0] entry_count;

  sorted_key_table #(.CAPACITY(Cap)) u_dut (.*);

  always #5 clk = ~clk;

  key_t table_keys [Cap];
  int unsigned table_count;
  answer_t pending_answers [$];
  int errors;

  key_t pool [6];

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic key_t canonical(input key_t k);
    key_t r;
    bit ended;
    r = k;
    ended = 0;
    for (int b = 0; b < 64; b++) begin
      if (ended) r[b / 8][63 - 8 * (b % 8) -: 8] = 8'h00;
      else if (r[b / 8][63 - 8 * (b % 8) -: 8] == 8'h00) ended = 1;
    end
    return r;
  endfunction

  function automatic int compare_keys(input key_t a, input key_t b);
    for (int w = 0; w < 8; w++) begin
      if (a[w] < b[w]) return -1;
      if (a[w] > b[w]) return 1;
    end
    return 0;
  endfunction

  function automatic answer_t apply_command(input command_t c);
    answer_t a;
    key_t k;
    int unsigned pos;
    k = canonical(c.key);
    a.st = STATUS_DONE;
    a.fnd = 0;
    case (c.op)
      OP_INSERT: begin
        if (table_count >= Cap) a.st = STATUS_FULL;
        else begin
          pos = table_count;
          while (pos > 0 && compare_keys(k, table_keys[pos - 1]) < 0) begin
            table_keys[pos] = table_keys[pos - 1];
            pos--;
          end
          table_keys[pos] = k;
          table_count++;
        end
      end
      OP_REMOVE: begin
        if (c.idx >= table_count) a.st = STATUS_RANGE;
        else begin
          for (int i = c.idx; i + 1 < table_count; i++) table_keys[i] = table_keys[i + 1];
          table_count--;
        end
      end
      OP_LOOKUP: begin
        for (int i = 0; i < table_count; i++)
          if (compare_keys(k, table_keys[i]) == 0) a.fnd = 1;
      end
      default: ;
    endcase
    a.cnt = table_count[3:0];
    return a;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic key_t random_key();
    key_t k;
    int len;
    case ($urandom_range(0, 3))
      0: foreach (k[w]) k[w] = rand64();
      1: k = pool[$urandom_range(0, 5)];
      default: begin
        len = $urandom_range(0, 12);
        foreach (k[w]) k[w] = rand64();
        for (int b = 0; b < 64; b++)
          if (b >= len) k[b / 8][63 - 8 * (b % 8) -: 8] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
          else k[b / 8][63 - 8 * (b % 8) -: 8] = 8'($urandom_range(1, 4));
        if (len < 64) k[len / 8][63 - 8 * (len % 8) -: 8] = 8'h00;
      end
    endcase
    return k;
  endfunction

  function automatic key_t fill_key(input logic [63:0] v);
    key_t k;
    foreach (k[w]) k[w] = v;
    return k;
  endfunction

  function automatic int gap_length();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  task automatic send_command(input command_t c, input bit has_answer, input answer_t want);
    answer_t a;
    repeat (1 + gap_length() * $urandom_range(0, 1)) @(negedge clk);
    operation <= c.op;
    entry_index <= c.idx;
    {key_word_0, key_word_1, key_word_2, key_word_3} <= {c.key[0], c.key[1], c.key[2], c.key[3]};
    {key_word_4, key_word_5, key_word_6, key_word_7} <= {c.key[4], c.key[5], c.key[6], c.key[7]};
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    a = apply_command(c);
    if (has_answer && a != want)
      report_mismatch($sformatf("table row disagrees with predictor for op %s", c.op.name()));
    pending_answers.push_back(a);
    @(negedge clk);
    in_valid <= 0;
  endtask

  always @(negedge clk) begin
    if (out_stall) out_stall <= $urandom_range(0, 2) != 0;
    else out_stall <= $urandom_range(0, 5) == 0;
  end

  always @(posedge clk) begin
    answer_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) report_mismatch("result with no command outstanding");
      else begin
        w = pending_answers.pop_front();
        if (status !== w.st)
          report_mismatch($sformatf("status %0d, wanted %0d", status, w.st));
        if (found !== w.fnd)
          report_mismatch($sformatf("found %0d, wanted %0d", found, w.fnd));
        if (entry_count !== w.cnt)
          report_mismatch($sformatf("entry_count %0d, wanted %0d", entry_count, w.cnt));
      end
    end
  end

  initial begin
    #20ms;
    $display("FAIL sorted_key_table");
    $finish;
  end

  initial begin
    row_t rows [$];
    command_t c;
    answer_t none;
    int r;
    none = '{STATUS_DONE, 0, 0};
    foreach (pool[i]) pool[i] = random_key();
    pool[0] = fill_key('1);
    pool[1] = fill_key('0);
    table_count = 0;
    rows.push_back('{'{OP_REMOVE, 3'd0, fill_key('0)}, 1, '{STATUS_RANGE, 0, 4'd0}});
    rows.push_back('{'{OP_LOOKUP, 3'd0, fill_key('0)}, 1, '{STATUS_DONE, 0, 4'd0}});
    rows.push_back('{'{OP_UNUSED, 3'd7, fill_key('1)}, 1, '{STATUS_DONE, 0, 4'd0}});
    rows.push_back('{'{OP_INSERT, 3'd0, fill_key('1)}, 1, '{STATUS_DONE, 0, 4'd1}});
    rows.push_back('{'{OP_INSERT, 3'd0, fill_key('0)}, 1, '{STATUS_DONE, 0, 4'd2}});
    rows.push_back('{'{OP_INSERT, 3'd0, fill_key('1)}, 1, '{STATUS_DONE, 0, 4'd3}});
    rows.push_back('{'{OP_LOOKUP, 3'd0, fill_key('1)}, 1, '{STATUS_DONE, 1, 4'd3}});
    c = '{OP_LOOKUP, 3'd0, fill_key('0)};
    c.key[0] = 64'h0011_2233_4455_6677;
    rows.push_back('{c, 1, '{STATUS_DONE, 1, 4'd3}});
    c.op = OP_INSERT;
    c.key[0] = 64'h4142_0043_4445_4647;
    rows.push_back('{c, 0, none});
    c.op = OP_LOOKUP;
    c.key = fill_key(64'h4142_00FF_FFFF_FFFF);
    rows.push_back('{c, 1, '{STATUS_DONE, 1, 4'd4}});
    for (int i = 0; i < 5; i++) rows.push_back('{'{OP_INSERT, 3'd0, pool[i]}, 0, none});
    rows.push_back('{'{OP_INSERT, 3'd0, pool[2]}, 1, '{STATUS_FULL, 0, 4'd8}});
    rows.push_back('{'{OP_UNUSED, 3'd0, pool[3]}, 1, '{STATUS_DONE, 0, 4'd8}});
    rows.push_back('{'{OP_REMOVE, 3'd7, pool[0]}, 1, '{STATUS_DONE, 0, 4'd7}});
    rows.push_back('{'{OP_REMOVE, 3'd7, pool[0]}, 1, '{STATUS_RANGE, 0, 4'd7}});
    rows.push_back('{'{OP_REMOVE, 3'd3, pool[0]}, 0, none});
    rows.push_back('{'{OP_LOOKUP, 3'd0, pool[4]}, 0, none});
    for (int i = 0; i < 6; i++) rows.push_back('{'{OP_REMOVE, 3'd0, pool[1]}, 0, none});
    rows.push_back('{'{OP_REMOVE, 3'd0, pool[1]}, 1, '{STATUS_RANGE, 0, 4'd0}});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    foreach (rows[i]) send_command(rows[i].cmd, rows[i].has_answer, rows[i].ans);
    for (int n = 0; n < 1750; n++) begin
      if (n % 200 == 0) foreach (pool[i]) pool[i] = random_key();
      r = $urandom_range(0, 99);
      c.key = random_key();
      c.idx = 3'($urandom);
      if (r < 45) c.op = OP_INSERT;
      else if (r < 75) c.op = OP_REMOVE;
      else if (r < 97) c.op = OP_LOOKUP;
      else c.op = OP_UNUSED;
      if (c.op == OP_REMOVE && r < 70 && table_count > 0)
        c.idx = 3'($urandom_range(0, table_count - 1));
      if (c.op == OP_LOOKUP && r < 88 && table_count > 0)
        c.key = table_keys[$urandom_range(0, table_count - 1)];
      send_command(c, 0, none);
    end
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASS sorted_key_table");
    else $display("FAIL sorted_key_table");
    $finish;
  end

endmodule

// ===== sorted_key_table.f =====
design/skt_pkg.sv
design/skt_ctrl.sv
design/skt_datapath.sv
design/sorted_key_table.sv
test/sorted_key_table_tb.sv
